// ----- hw/rtl/lpb_pkg.sv -----
// Shared types, constants and helpers for the long-press button detector.
// No dependencies; used by lpb_step and long_press_button_fsm.
package lpb_pkg;

  localparam int CNT_W  = 16;
  localparam int MODE_W = 2;
  localparam int CIDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX       = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] DEBOUNCE_RST  = CNT_W'(5);
  localparam logic [CNT_W-1:0] READY_RST     = CNT_W'(200);
  localparam logic [CNT_W-1:0] EMERGENCY_RST = CNT_W'(500);

  typedef enum logic [CIDX_W-1:0] {
    CFG_DEBOUNCE  = 2'd0,
    CFG_READY     = 2'd1,
    CFG_EMERGENCY = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    MODE_IDLE      = 4'b0001,
    MODE_CHARGING  = 4'b0010,
    MODE_READY     = 4'b0100,
    MODE_EMERGENCY = 4'b1000
  } mode_t;

  localparam logic [MODE_W-1:0] CODE_IDLE      = 2'd0;
  localparam logic [MODE_W-1:0] CODE_CHARGING  = 2'd1;
  localparam logic [MODE_W-1:0] CODE_READY     = 2'd2;
  localparam logic [MODE_W-1:0] CODE_EMERGENCY = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0] debounce;
    logic [CNT_W-1:0] ready;
    logic [CNT_W-1:0] emergency;
  } cfg_t;

  typedef struct packed {
    logic             level;
    mode_t            mode;
    logic [CNT_W-1:0] hold;
    logic [CNT_W-1:0] since;
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              ready_pulse;
    logic              emergency_pulse;
    logic              listen_done_pulse;
  } result_t;

  function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
    logic [MODE_W-1:0] c;
    case (m)
      MODE_IDLE:      c = CODE_IDLE;
      MODE_CHARGING:  c = CODE_CHARGING;
      MODE_READY:     c = CODE_READY;
      MODE_EMERGENCY: c = CODE_EMERGENCY;
      default:        c = CODE_IDLE;
    endcase
    return c;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
    return r;
  endfunction

endpackage

// ----- hw/rtl/lpb_step.sv -----
// One poll tick of the detector: next state and result word from current state.
// Depends on lpb_pkg.
module lpb_step (
  input  logic            pin,
  input  lpb_pkg::cfg_t   cfg,
  input  lpb_pkg::state_t cur,
  output lpb_pkg::state_t nxt,
  output lpb_pkg::result_t res
);
  import lpb_pkg::*;

  logic  rise;
  logic  fall;
  logic  rdy;
  logic  emg;
  logic  done;
  mode_t m;
  mode_t held;
  logic [CNT_W-1:0] h;
  logic [CNT_W-1:0] s;

  assign rise = pin & ~cur.level;
  assign fall = ~pin & cur.level;

  always_comb begin
    rdy  = 1'b0;
    emg  = 1'b0;
    done = 1'b0;
    m    = cur.mode;
    h    = sat_inc(cur.hold);
    s    = sat_inc(cur.since);

    if (rise && (s > cfg.debounce)) begin
      m = MODE_CHARGING;
      h = '0;
    end

    if (fall) begin
      s = '0;
      m = MODE_IDLE;
      if (cur.mode == MODE_EMERGENCY) begin
        emg = 1'b1;
      end else if ((cur.mode == MODE_CHARGING || cur.mode == MODE_READY) &&
                   (h >= cfg.ready)) begin
        done = 1'b1;
      end
    end

    held = m;
    if (pin) begin
      if (held == MODE_CHARGING && h >= cfg.ready) begin
        m   = MODE_READY;
        rdy = 1'b1;
      end
      if ((held == MODE_CHARGING || held == MODE_READY) && h >= cfg.emergency) begin
        m   = MODE_EMERGENCY;
        emg = 1'b1;
      end
    end

    nxt.level = pin;
    nxt.mode  = m;
    nxt.hold  = h;
    nxt.since = s;

    res.mode              = mode_code(m);
    res.ready_pulse       = rdy;
    res.emergency_pulse   = emg;
    res.listen_done_pulse = done;
  end

endmodule

// ----- hw/rtl/long_press_button_fsm.sv -----
// Long-press button detector: one sampled level in, one event word out per tick.
// Data path: the input word is accepted into the input register, and its result word is
//   loaded into the output register when the output register is empty or not stalled.
// Throughput: one word per cycle unless out_stall holds; each register holds one word.
// Reset: rst_n (sync, active low) restores default thresholds, idle mode, hold 0,
//   release counter saturated, and empties both registers.
// Depends on lpb_pkg and lpb_step.
module long_press_button_fsm (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_pin_pressed,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_mode,
  output logic                      out_ready_pulse,
  output logic                      out_emergency_pulse,
  output logic                      out_listen_done_pulse,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lpb_pkg::CIDX_W-1:0] cfg_index,
  input  logic [lpb_pkg::CNT_W-1:0]  cfg_data
);
  import lpb_pkg::*;

  cfg_t    cfg_r;
  state_t  st_r;
  state_t  st_nxt;
  result_t res_nxt;
  result_t out_r;
  logic    s1_valid_r;
  logic    s1_pin_r;
  logic    out_valid_r;
  logic    out_load;
  logic    s1_load;

  assign out_load  = s1_valid_r && (!out_valid_r || !out_stall);
  assign s1_load   = in_valid && !in_stall;
  assign in_stall  = s1_valid_r && !out_load;
  assign cfg_ready = 1'b1;

  lpb_step u_step (
    .pin (s1_pin_r),
    .cfg (cfg_r),
    .cur (st_r),
    .nxt (st_nxt),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce  <= DEBOUNCE_RST;
      cfg_r.ready     <= READY_RST;
      cfg_r.emergency <= EMERGENCY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEBOUNCE:  cfg_r.debounce  <= cfg_data;
        CFG_READY:     cfg_r.ready     <= cfg_data;
        CFG_EMERGENCY: cfg_r.emergency <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.level  <= 1'b0;
      st_r.mode   <= MODE_IDLE;
      st_r.hold   <= '0;
      st_r.since  <= CNT_MAX;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        st_r <= st_nxt;
      end
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (out_load) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_pin_r <= in_pin_pressed;
    end
    if (out_load) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_mode              = out_r.mode;
  assign out_ready_pulse       = out_r.ready_pulse;
  assign out_emergency_pulse   = out_r.emergency_pulse;
  assign out_listen_done_pulse = out_r.listen_done_pulse;

endmodule
